// ----- rtl/core/rpvg_pkg.sv -----
// Shared types, constants and small functions of the polygon vertex generator.
package rpvg_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_PHASE_BITS   = 16;

  localparam int RADIUS_W = 16;
  localparam int COORD_W  = 17;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int THETA_W  = 31;
  localparam int ACC_W    = 34;
  localparam int MAG_W    = 31;
  localparam int TERM_W   = 32;
  localparam int KW       = 3;
  localparam int TERMS    = 7;
  localparam int FRAC_SH  = 30;

  // 2*pi in Q30 is 2^32 plus this lower part
  localparam logic [MUL_W-1:0] TWO_PI_LO = 32'd2451551556;
  localparam logic [ACC_W-1:0] ONE_Q30   = ACC_W'(64'd1 << FRAC_SH);

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_ADIV   = 4'd2,
    OP_ANGLE  = 4'd3,
    OP_MUL_F  = 4'd4,
    OP_THETA  = 4'd5,
    OP_MUL_SQ = 4'd6,
    OP_SQ     = 4'd7,
    OP_MUL_T  = 4'd8,
    OP_TDIV   = 4'd9,
    OP_TERM   = 4'd10,
    OP_MUL_X  = 4'd11,
    OP_MUL_YX = 4'd12,
    OP_TAKE_Y = 4'd13,
    OP_EMIT   = 4'd14
  } dp_op_e;

  typedef struct packed {
    dp_op_e          op;
    logic [KW-1:0]   term_k;
    logic            term_cos;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
    logic zero_count;
  } stat_t;

  // Series divisors d are replaced by m = ceil(2^(32+l)/d), l = ceil(log2 d).
  // m lies in [2^32, 2^33), so only its low 32 bits are kept here; the
  // quotient is (x*m_lo + x*2^32) >> (32+l), exact for any 32-bit x.

  // sine series divisor (2k)(2k+1)
  function automatic logic [MUL_W-1:0] sin_rcp(input logic [KW-1:0] k);
    logic [MUL_W-1:0] m;
    unique case (k)
      3'd1:    m = MUL_W'(((64'd1 << 35) + 64'd5) / 64'd6);
      3'd2:    m = MUL_W'(((64'd1 << 37) + 64'd19) / 64'd20);
      3'd3:    m = MUL_W'(((64'd1 << 38) + 64'd41) / 64'd42);
      3'd4:    m = MUL_W'(((64'd1 << 39) + 64'd71) / 64'd72);
      3'd5:    m = MUL_W'(((64'd1 << 39) + 64'd109) / 64'd110);
      3'd6:    m = MUL_W'(((64'd1 << 40) + 64'd155) / 64'd156);
      3'd7:    m = MUL_W'(((64'd1 << 40) + 64'd209) / 64'd210);
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] sin_rsh(input logic [KW-1:0] k);
    logic [3:0] s;
    unique case (k)
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd5;
      3'd3:    s = 4'd6;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd7;
      3'd6:    s = 4'd8;
      3'd7:    s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // cosine series divisor (2k-1)(2k)
  function automatic logic [MUL_W-1:0] cos_rcp(input logic [KW-1:0] k);
    logic [MUL_W-1:0] m;
    unique case (k)
      3'd1:    m = MUL_W'(((64'd1 << 33) + 64'd1) / 64'd2);
      3'd2:    m = MUL_W'(((64'd1 << 36) + 64'd11) / 64'd12);
      3'd3:    m = MUL_W'(((64'd1 << 37) + 64'd29) / 64'd30);
      3'd4:    m = MUL_W'(((64'd1 << 38) + 64'd55) / 64'd56);
      3'd5:    m = MUL_W'(((64'd1 << 39) + 64'd89) / 64'd90);
      3'd6:    m = MUL_W'(((64'd1 << 40) + 64'd131) / 64'd132);
      3'd7:    m = MUL_W'(((64'd1 << 40) + 64'd181) / 64'd182);
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] cos_rsh(input logic [KW-1:0] k);
    logic [3:0] s;
    unique case (k)
      3'd1:    s = 4'd1;
      3'd2:    s = 4'd4;
      3'd3:    s = 4'd5;
      3'd4:    s = 4'd6;
      3'd5:    s = 4'd7;
      3'd6:    s = 4'd8;
      3'd7:    s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // clamp a signed Q30 sum to [0, 1.0]
  function automatic logic [MAG_W-1:0] clamp_q30(input logic signed [ACC_W-1:0] v);
    logic [MAG_W-1:0] m;
    if (v < 0) begin
      m = '0;
    end else if ($unsigned(v) > ONE_Q30) begin
      m = ONE_Q30[MAG_W-1:0];
    end else begin
      m = v[MAG_W-1:0];
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/rpvg_div.sv -----
// Unsigned radix-16 restoring divider, four quotient bits per cycle.
module rpvg_div #(
  parameter int DW = 32,
  parameter int VW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int DIGITS = DW / 4;
  localparam int CNTW   = $clog2(DIGITS + 1);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   num_q, quo_q;
  logic [VW-1:0]   rem_q, den_q;
  logic [VW-1:0]   rem_d;
  logic [3:0]      qdig;

  always_comb begin
    logic [VW:0]   t;
    logic [VW-1:0] r;
    r = rem_q;
    qdig = '0;
    for (int j = 0; j < 4; j++) begin
      t = {r, num_q[DW-1-j]};
      if (t >= {1'b0, den_q}) begin
        t = t - {1'b0, den_q};
        qdig[3-j] = 1'b1;
      end
      r = t[VW-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DIGITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DW-5:0], 4'b0000};
      quo_q <= {quo_q[DW-5:0], qdig};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/rpvg_datapath.sv -----
// Datapath: operand registers, shared multiplier, divider, series sums and result register.
module rpvg_datapath #(
  parameter int MAX_VERTICES = rpvg_pkg::DEF_MAX_VERTICES,
  parameter int PHASE_BITS   = rpvg_pkg::DEF_PHASE_BITS,
  localparam int CW = $clog2(MAX_VERTICES + 1),
  localparam int IW = $clog2(MAX_VERTICES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rpvg_pkg::cmd_t                cmd_i,
  output rpvg_pkg::stat_t               stat_o,
  input  logic [CW-1:0]                 vertex_count_i,
  input  logic [rpvg_pkg::RADIUS_W-1:0] radius_i,
  output logic [IW-1:0]                 vertex_index_o,
  output logic signed [rpvg_pkg::COORD_W-1:0] coord_x_o,
  output logic signed [rpvg_pkg::COORD_W-1:0] coord_y_o,
  output logic                          last_vertex_o
);

  localparam int FW   = PHASE_BITS - 2;
  localparam int NUMW = IW + PHASE_BITS;
  localparam int DW   = (NUMW + 3) / 4 * 4;
  localparam int VW   = CW;
  localparam int MW   = rpvg_pkg::MUL_W;
  localparam int PW   = rpvg_pkg::PROD_W;
  localparam int XW   = rpvg_pkg::COORD_W;
  localparam int SH   = rpvg_pkg::FRAC_SH;

  logic [CW-1:0]               n_q;
  logic [rpvg_pkg::RADIUS_W-1:0] r_q;
  logic [IW-1:0]               idx_q;
  logic [PHASE_BITS-1:0]       a_q;
  logic [rpvg_pkg::THETA_W-1:0] theta_q;
  logic [rpvg_pkg::TERM_W-1:0] th2_q, ts_q, tc_q;
  logic [rpvg_pkg::TERM_W-1:0] tnum_q;
  logic signed [rpvg_pkg::ACC_W-1:0] ss_q, cs_q;
  logic [PW-1:0]               prod_q;
  logic [XW-1:0]               x_q;
  logic [IW-1:0]               oidx_q;
  logic [XW-1:0]               ox_q, oy_q;
  logic [XW-1:0]               oy_hold_q;
  logic                        olast_q;

  logic [MW-1:0]  mul_a, mul_b;
  logic [FW-1:0]  frac;
  logic [1:0]     quad;
  logic [rpvg_pkg::MAG_W-1:0] s_mag, c_mag, smag, cmag;
  logic           xneg, yneg;
  logic [PW:0]    th_sum;
  logic [PW:0]    q_sum;
  logic [PW-MW:0] q_hi;
  logic [MW-1:0]  rcp;
  logic [3:0]     rsh;
  logic [PW-1:0]  rnd;
  logic [XW-1:0]  scaled;
  logic           div_start;
  logic [DW-1:0]  div_num, div_quo;
  logic [VW-1:0]  div_den;
  logic           div_done;
  logic           is_last;
  logic [CW-1:0]  n_sat;
  logic [rpvg_pkg::TERM_W-1:0] term;

  assign frac  = a_q[FW-1:0];
  assign quad  = a_q[PHASE_BITS-1:PHASE_BITS-2];
  assign s_mag = rpvg_pkg::clamp_q30(ss_q);
  assign c_mag = rpvg_pkg::clamp_q30(cs_q);

  // quadrant fixes swap and signs; x is the negated sine
  always_comb begin
    unique case (quad)
      2'd0: begin smag = s_mag; cmag = c_mag; xneg = 1'b1; yneg = 1'b0; end
      2'd1: begin smag = c_mag; cmag = s_mag; xneg = 1'b1; yneg = 1'b1; end
      2'd2: begin smag = s_mag; cmag = c_mag; xneg = 1'b0; yneg = 1'b1; end
      default: begin smag = c_mag; cmag = s_mag; xneg = 1'b0; yneg = 1'b0; end
    endcase
  end

  // reciprocal and shift of the current series divisor
  assign rcp = cmd_i.term_cos ? rpvg_pkg::cos_rcp(cmd_i.term_k)
                              : rpvg_pkg::sin_rcp(cmd_i.term_k);
  assign rsh = cmd_i.term_cos ? rpvg_pkg::cos_rsh(cmd_i.term_k)
                              : rpvg_pkg::sin_rsh(cmd_i.term_k);

  always_comb begin
    unique case (cmd_i.op)
      rpvg_pkg::OP_MUL_F: begin
        mul_a = MW'(frac);
        mul_b = rpvg_pkg::TWO_PI_LO;
      end
      rpvg_pkg::OP_MUL_SQ: begin
        mul_a = MW'(theta_q);
        mul_b = MW'(theta_q);
      end
      rpvg_pkg::OP_MUL_T: begin
        mul_a = cmd_i.term_cos ? tc_q : ts_q;
        mul_b = th2_q;
      end
      rpvg_pkg::OP_TDIV: begin
        mul_a = prod_q[SH +: MW];
        mul_b = rcp;
      end
      rpvg_pkg::OP_MUL_X: begin
        mul_a = MW'(r_q);
        mul_b = MW'(smag);
      end
      rpvg_pkg::OP_MUL_YX: begin
        mul_a = MW'(r_q);
        mul_b = MW'(cmag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // theta = (f * 2pi_q30 + half) >> PHASE_BITS, with 2pi split as 2^32 + low part
  assign th_sum = {1'b0, prod_q} + ((PW+1)'(frac) << MW) + ((PW+1)'(1) << (PHASE_BITS - 1));
  assign rnd    = prod_q + (PW'(1) << (SH - 1));
  assign scaled = rnd[SH +: XW];

  // series term: x / d = (x*m_lo + x*2^32) >> (32 + l)
  assign q_sum = {1'b0, prod_q} + ((PW+1)'(tnum_q) << MW);
  assign q_hi  = q_sum[PW:MW];
  assign term  = rpvg_pkg::TERM_W'(q_hi >> rsh);

  assign div_start = (cmd_i.op == rpvg_pkg::OP_ADIV);
  assign div_num   = DW'({idx_q, {PHASE_BITS{1'b0}}});
  assign div_den   = n_q;

  rpvg_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign is_last = ((CW'(idx_q) + 1'b1) == n_q);
  assign n_sat   = (vertex_count_i > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vertex_count_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      r_q   <= '0;
      idx_q <= '0;
      a_q   <= '0;
    end else begin
      if (cmd_i.op == rpvg_pkg::OP_LOAD) begin
        n_q   <= n_sat;
        r_q   <= radius_i;
        idx_q <= '0;
      end
      if (cmd_i.op == rpvg_pkg::OP_ANGLE) begin
        a_q <= div_quo[PHASE_BITS-1:0];
      end
      if ((cmd_i.op == rpvg_pkg::OP_EMIT) && !is_last) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      rpvg_pkg::OP_THETA: begin
        theta_q <= th_sum[PHASE_BITS +: rpvg_pkg::THETA_W];
      end
      rpvg_pkg::OP_SQ: begin
        th2_q <= prod_q[SH +: rpvg_pkg::TERM_W];
        ts_q  <= rpvg_pkg::TERM_W'(theta_q);
        tc_q  <= rpvg_pkg::ONE_Q30[rpvg_pkg::TERM_W-1:0];
        ss_q  <= $signed(rpvg_pkg::ACC_W'(theta_q));
        cs_q  <= $signed(rpvg_pkg::ONE_Q30);
      end
      rpvg_pkg::OP_TDIV: begin
        tnum_q <= prod_q[SH +: rpvg_pkg::TERM_W];
      end
      rpvg_pkg::OP_TERM: begin
        if (cmd_i.term_cos) begin
          tc_q <= term;
          cs_q <= cmd_i.term_k[0] ? cs_q - $signed(rpvg_pkg::ACC_W'(term))
                                  : cs_q + $signed(rpvg_pkg::ACC_W'(term));
        end else begin
          ts_q <= term;
          ss_q <= cmd_i.term_k[0] ? ss_q - $signed(rpvg_pkg::ACC_W'(term))
                                  : ss_q + $signed(rpvg_pkg::ACC_W'(term));
        end
      end
      rpvg_pkg::OP_MUL_YX: begin
        x_q <= xneg ? (XW'(0) - scaled) : scaled;
      end
      rpvg_pkg::OP_TAKE_Y: begin
        oy_q <= yneg ? (XW'(0) - scaled) : scaled;
      end
      rpvg_pkg::OP_EMIT: begin
        oidx_q  <= idx_q;
        ox_q    <= x_q;
        olast_q <= is_last;
      end
      default: begin
      end
    endcase
  end

  // y waits in oy_q until the emit step loads it with the rest of the vertex
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rpvg_pkg::OP_EMIT) begin
      oy_hold_q <= oy_q;
    end
  end

  assign vertex_index_o = oidx_q;
  assign coord_x_o      = $signed(ox_q);
  assign coord_y_o      = $signed(oy_hold_q);
  assign last_vertex_o  = olast_q;

  assign stat_o.div_done   = div_done;
  assign stat_o.last       = is_last;
  assign stat_o.zero_count = (vertex_count_i == '0);

endmodule

// ----- rtl/core/rpvg_ctrl.sv -----
// Controller: sequences one vertex at a time and owns both handshakes.
module rpvg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rpvg_pkg::cmd_t  cmd_o,
  input  rpvg_pkg::stat_t stat_i
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_ADIV   = 14'b00000000000010,
    S_AWAIT  = 14'b00000000000100,
    S_THMUL  = 14'b00000000001000,
    S_THADD  = 14'b00000000010000,
    S_SQMUL  = 14'b00000000100000,
    S_SQTAKE = 14'b00000001000000,
    S_TMUL   = 14'b00000010000000,
    S_TDIV   = 14'b00000100000000,
    S_TWAIT  = 14'b00001000000000,
    S_XMUL   = 14'b00010000000000,
    S_YMUL   = 14'b00100000000000,
    S_YTAKE  = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic [rpvg_pkg::KW-1:0] k_q, k_d;
  logic cos_q, cos_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    cos_d         = cos_q;
    cmd_o.op      = rpvg_pkg::OP_NONE;
    cmd_o.term_k  = k_q;
    cmd_o.term_cos = cos_q;
    out_valid_d   = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !stat_i.zero_count) begin
          cmd_o.op = rpvg_pkg::OP_LOAD;
          state_d  = S_ADIV;
        end
      end
      S_ADIV: begin
        cmd_o.op = rpvg_pkg::OP_ADIV;
        state_d  = S_AWAIT;
      end
      S_AWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = rpvg_pkg::OP_ANGLE;
          state_d  = S_THMUL;
        end
      end
      S_THMUL: begin
        cmd_o.op = rpvg_pkg::OP_MUL_F;
        state_d  = S_THADD;
      end
      S_THADD: begin
        cmd_o.op = rpvg_pkg::OP_THETA;
        state_d  = S_SQMUL;
      end
      S_SQMUL: begin
        cmd_o.op = rpvg_pkg::OP_MUL_SQ;
        state_d  = S_SQTAKE;
      end
      S_SQTAKE: begin
        cmd_o.op = rpvg_pkg::OP_SQ;
        k_d      = rpvg_pkg::KW'(1);
        cos_d    = 1'b0;
        state_d  = S_TMUL;
      end
      S_TMUL: begin
        cmd_o.op = rpvg_pkg::OP_MUL_T;
        state_d  = S_TDIV;
      end
      S_TDIV: begin
        cmd_o.op = rpvg_pkg::OP_TDIV;
        state_d  = S_TWAIT;
      end
      S_TWAIT: begin
        cmd_o.op = rpvg_pkg::OP_TERM;
        if (!cos_q) begin
          cos_d   = 1'b1;
          state_d = S_TMUL;
        end else begin
          cos_d = 1'b0;
          if (k_q == rpvg_pkg::KW'(rpvg_pkg::TERMS)) begin
            state_d = S_XMUL;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_TMUL;
          end
        end
      end
      S_XMUL: begin
        cmd_o.op = rpvg_pkg::OP_MUL_X;
        state_d  = S_YMUL;
      end
      S_YMUL: begin
        cmd_o.op = rpvg_pkg::OP_MUL_YX;
        state_d  = S_YTAKE;
      end
      S_YTAKE: begin
        cmd_o.op = rpvg_pkg::OP_TAKE_Y;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.op    = rpvg_pkg::OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = stat_i.last ? S_IDLE : S_ADIV;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      cos_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      cos_q       <= cos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == rpvg_pkg::OP_EMIT) |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled beat");

  a_start_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !stat_i.zero_count) |=> (state_q == S_ADIV))
    else $error("accepted polygon did not start");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_o.op == rpvg_pkg::OP_EMIT) && stat_i.last) |=> (state_q == S_IDLE))
    else $error("sequencer kept running past the last vertex");

  a_term_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_TMUL) || (state_q == S_TDIV) || (state_q == S_TWAIT)) |->
    ((k_q != '0) && (k_q <= rpvg_pkg::KW'(rpvg_pkg::TERMS))))
    else $error("series term index out of range");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == rpvg_pkg::OP_EMIT) |=> out_valid_o)
    else $error("emitted vertex not presented");

endmodule

// ----- rtl/core/regular_polygon_vertex_generator.sv -----
// Top level of the regular polygon vertex generator: controller plus datapath.
// Vertices are computed one at a time; a polygon beat is taken only in idle, after the
//   last vertex of the previous polygon is emitted. The pace is set by the angle division
//   on the 4-bit-per-cycle divider, fourteen series terms (each a multiply, a reciprocal
//   multiply and a take), and the shared 32x32 multiplier. A stalled vertex beat holds
//   the next emit.
// A beat with zero count is taken and dropped. rst_ni clears the sequencer and
//   valid flags at once; no clearing pass is needed.
module regular_polygon_vertex_generator #(
  parameter int MAX_VERTICES = rpvg_pkg::DEF_MAX_VERTICES,
  parameter int PHASE_BITS   = rpvg_pkg::DEF_PHASE_BITS,
  localparam int CW = $clog2(MAX_VERTICES + 1),
  localparam int IW = $clog2(MAX_VERTICES)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // polygon request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CW-1:0]                 vertex_count_i,
  input  logic [rpvg_pkg::RADIUS_W-1:0] radius_i,
  // vertex channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [IW-1:0]                 vertex_index_o,
  output logic signed [rpvg_pkg::COORD_W-1:0] coord_x_o,
  output logic signed [rpvg_pkg::COORD_W-1:0] coord_y_o,
  output logic                          last_vertex_o
);

  // Command and status between sequencer and datapath. The sequencer walks each
  // vertex through: angle division, theta scaling, theta squared, seven sine and
  // seven cosine series terms (multiply by theta squared, then multiply by the
  // reciprocal of the term divisor and shift), two radius products, and a load
  // into the output register. The output register holds a finished vertex while
  // the next one is computed and while a new polygon beat is taken in.
  rpvg_pkg::cmd_t  cmd;
  rpvg_pkg::stat_t stat;

  rpvg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rpvg_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .PHASE_BITS   (PHASE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .vertex_count_i (vertex_count_i),
    .radius_i       (radius_i),
    .vertex_index_o (vertex_index_o),
    .coord_x_o      (coord_x_o),
    .coord_y_o      (coord_y_o),
    .last_vertex_o  (last_vertex_o)
  );

endmodule

// ----- tb/regular_polygon_vertex_generator_checker.sv -----
// Vertex checker: predicts the vertices of each polygon beat and compares the results.
`timescale 1ns / 1ps
module regular_polygon_vertex_generator_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [6:0]          vertex_count_i,
  input  logic [15:0]         radius_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [5:0]          vertex_index_i,
  input  logic signed [16:0]  coord_x_i,
  input  logic signed [16:0]  coord_y_i,
  input  logic                last_vertex_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct {
    logic [5:0]         index;
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               last;
  } vertex_t;

  localparam longint unsigned UNIT      = 64'd1 << 30;
  localparam longint unsigned TURN_Q30  = 64'd6746518852;

  vertex_t vertex_q[$];
  int      fails;

  assign fail_count_o = fails;
  assign pending_o    = vertex_q.size();

  // Taylor sine and cosine magnitudes of an angle in [0, pi/2), Q30
  function automatic void series_sincos(input longint unsigned theta,
                                        output longint unsigned s_mag,
                                        output longint unsigned c_mag);
    longint unsigned sq, ts, tc;
    longint          ssum, csum;
    sq   = (theta * theta) >> 30;
    ts   = theta;
    tc   = UNIT;
    ssum = longint'(theta);
    csum = longint'(UNIT);
    for (int k = 1; k <= 7; k++) begin
      ts = ((ts * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      tc = ((tc * sq) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        ssum -= longint'(ts);
        csum -= longint'(tc);
      end else begin
        ssum += longint'(ts);
        csum += longint'(tc);
      end
    end
    s_mag = (ssum < 0) ? 0 : (longint'(UNIT) < ssum) ? UNIT : longint'(ssum);
    c_mag = (csum < 0) ? 0 : (longint'(UNIT) < csum) ? UNIT : longint'(csum);
  endfunction

  // radius times a Q30 magnitude, rounded half away from zero, to signed Q9.8 for a Q8.8 radius
  function automatic logic signed [16:0] scaled(input logic [15:0] r,
                                                input longint unsigned mag,
                                                input logic neg);
    longint unsigned p;
    p = (longint'(r) * mag + (UNIT >> 1)) >> 30;
    if (neg) p = 64'd0 - p;
    return p[16:0];
  endfunction

  // queue up every vertex of one polygon beat
  function automatic void predict_polygon(input logic [6:0] count, input logic [15:0] r);
    longint unsigned n, a, f, theta, s_mag, c_mag, xm, ym;
    logic    xneg, yneg;
    vertex_t v;
    n = count;
    if (n == 0) return;
    if (n > 64) n = 64;
    for (longint unsigned i = 0; i < n; i++) begin
      a     = ((i << 16) / n) & 64'hFFFF;
      f     = a & 64'h3FFF;
      theta = (f * TURN_Q30 + 64'd32768) >> 16;
      series_sincos(theta, s_mag, c_mag);
      case ((a >> 14) & 3)
        0: begin xm = s_mag; xneg = 1'b1; ym = c_mag; yneg = 1'b0; end
        1: begin xm = c_mag; xneg = 1'b1; ym = s_mag; yneg = 1'b1; end
        2: begin xm = s_mag; xneg = 1'b0; ym = c_mag; yneg = 1'b1; end
        default: begin xm = c_mag; xneg = 1'b0; ym = s_mag; yneg = 1'b0; end
      endcase
      v.index = i[5:0];
      v.x     = scaled(r, xm, xneg);
      v.y     = scaled(r, ym, yneg);
      v.last  = (i + 1 == n);
      vertex_q.push_back(v);
    end
  endfunction

  initial fails = 0;

  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) predict_polygon(vertex_count_i, radius_i);
      if (out_valid_i && !out_stall_i) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex beat idx=%0d x=%0d y=%0d last=%0b", $time,
                   vertex_index_i, coord_x_i, coord_y_i, last_vertex_i);
          fails++;
        end else begin
          want = vertex_q.pop_front();
          if (vertex_index_i !== want.index) begin
            $display("%0t: vertex_index expected %0d actual %0d", $time, want.index,
                     vertex_index_i);
            fails++;
          end
          if (coord_x_i !== want.x) begin
            $display("%0t: coord_x (idx %0d) expected %0d actual %0d", $time, want.index,
                     want.x, coord_x_i);
            fails++;
          end
          if (coord_y_i !== want.y) begin
            $display("%0t: coord_y (idx %0d) expected %0d actual %0d", $time, want.index,
                     want.y, coord_y_i);
            fails++;
          end
          if (last_vertex_i !== want.last) begin
            $display("%0t: last_vertex (idx %0d) expected %0b actual %0b", $time,
                     want.index, want.last, last_vertex_i);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/regular_polygon_vertex_generator_test.sv -----
// Top of the polygon vertex generator testbench: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module regular_polygon_vertex_generator_test;

  localparam int CYCLE_LIMIT  = 6000000;
  localparam int RANDOM_BEATS = 240;
  localparam int QUIET_BEATS  = 40;   // final beats sent with no idling on either side

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [6:0]         vertex_count_i;
  logic [15:0]        radius_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [5:0]         vertex_index_o;
  logic signed [16:0] coord_x_o;
  logic signed [16:0] coord_y_o;
  logic               last_vertex_o;

  int fail_count;
  int pending;
  int cycles;
  bit quiet;       // set once the idle-free tail of the run begins

  regular_polygon_vertex_generator uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .vertex_count_i, .radius_i,
    .out_valid_o, .out_stall_i, .vertex_index_o, .coord_x_o, .coord_y_o, .last_vertex_o
  );

  regular_polygon_vertex_generator_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .vertex_count_i, .radius_i,
    .out_valid_i(out_valid_o), .out_stall_i, .vertex_index_i(vertex_index_o),
    .coord_x_i(coord_x_o), .coord_y_i(coord_y_o), .last_vertex_i(last_vertex_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog: end the run if the block hangs.
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** regular_polygon_vertex_generator: FAILED **");
      $finish;
    end
  end

  // Offer one polygon beat and hold it until accepted; returns at a falling edge.
  task automatic send_polygon(input logic [6:0] count, input logic [15:0] r);
    in_valid_i     = 1'b1;
    vertex_count_i = count;
    radius_i       = r;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Now and then, outside the quiet tail, drop valid for a random burst.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  // Mostly small polygons keep the run short; a few zero, large and saturating counts.
  function automatic logic [6:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3)  return 7'd0;
    if (roll < 85) return 7'($urandom_range(1, 12));
    if (roll < 95) return 7'($urandom_range(13, 64));
    return 7'($urandom_range(65, 127));
  endfunction

  function automatic logic [15:0] pick_radius();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold-off to back the block up,
  // and no stalls at all in the tail.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    repeat (3000) @(negedge clk_i);
    out_stall_i = 1'b1;
    repeat (6000) @(negedge clk_i);
    out_stall_i = 1'b0;
    while (!quiet) begin
      @(negedge clk_i);
      if ($urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else begin
        repeat ($urandom_range(1, 40)) @(negedge clk_i);
      end
    end
    out_stall_i = 1'b0;
  end

  initial begin
    logic [6:0]  directed_count [16] = '{7'd1, 7'd1, 7'd2, 7'd3, 7'd0, 7'd4, 7'd5, 7'd6,
                                         7'd7, 7'd8, 7'd64, 7'd127, 7'd65, 7'd12, 7'd100,
                                         7'd3};
    logic [15:0] directed_radius [16] = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0001,
                                          16'h1234, 16'h8000, 16'h5555, 16'hAAAA,
                                          16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                                          16'h00FF, 16'hFF00, 16'h0002, 16'h0000};
    quiet          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    vertex_count_i = '0;
    radius_i       = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: single vertex, zero radius, full radius, zero count,
    // saturating counts, and the common small polygons.
    for (int i = 0; i < 16; i++) begin
      send_polygon(directed_count[i], directed_radius[i]);
      sender_gap();
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      // Pause once until the block has drained completely.
      if (i == RANDOM_BEATS / 2) begin
        in_valid_i = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      if (i == RANDOM_BEATS - QUIET_BEATS) quiet = 1'b1;
      send_polygon(pick_count(), pick_radius());
      sender_gap();
    end
    in_valid_i = 1'b0;

    while (pending != 0) @(negedge clk_i);
    // Let a trailing zero-count beat settle; no vertex may follow.
    repeat (400) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("** regular_polygon_vertex_generator: PASSED **");
    end else begin
      $display("** regular_polygon_vertex_generator: FAILED **");
    end
    $finish;
  end

endmodule
